// ===== rtl/bab_pkg.sv =====
// Shared types, constants and blend arithmetic for the brush alpha-blend blitter.
package bab_pkg;

    localparam int MAX_TEX_DIM   = 256;
    localparam int MAX_BRUSH_DIM = 64;
    localparam int TEX_AW        = $clog2(MAX_TEX_DIM);
    localparam int STORE_AW      = 2 * TEX_AW;
    localparam int STORE_DEPTH   = MAX_TEX_DIM * MAX_TEX_DIM;
    localparam int BCOL_W        = $clog2(MAX_BRUSH_DIM);
    localparam int CFG_W         = 9;
    localparam int CFG_IDX_W     = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_W   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_H   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRUSH_H = 2'd3;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_BLEND = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [15:0]        texel_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic signed [15:0] corner_x;
        logic signed [15:0] corner_y;
    } t_in_item;

    typedef struct packed {
        logic       inside_res;
        logic [7:0] texel_x;
        logic [7:0] texel_y;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       pass_last;
    } t_out_item;

    // Store layout: red in the low byte, alpha in the high byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_texel;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } t_blend_ctl;

    // floor(x / 255), exact for x below 65280 (quotient fits in 8 bits)
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        begin
            t = 17'(x) + 17'(x[15:8]) + 17'd1;
            return t[15:8];
        end
    endfunction

    // old + (new - old) * a / 255, quotient toward zero; stays between old and new
    function automatic logic [7:0] blend_channel(input logic [7:0] oldc,
                                                 input logic [7:0] newc,
                                                 input logic [7:0] a);
        logic [7:0]  mag;
        logic [15:0] prod;
        logic [7:0]  q;
        begin
            mag  = (newc >= oldc) ? (newc - oldc) : (oldc - newc);
            prod = 16'(mag) * 16'(a);
            q    = div255(prod);
            return (newc >= oldc) ? (oldc + q) : (oldc - q);
        end
    endfunction

    function automatic logic [7:0] sat_add8(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] s;
        begin
            s = 9'(x) + 9'(y);
            return s[8] ? 8'hFF : s[7:0];
        end
    endfunction

endpackage

// ===== rtl/bab_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bab_blend.sv =====
// Two-stage blend datapath: lerp and alpha sum, then premultiply by the summed alpha.
module bab_blend (
    input  logic                i_clk,
    input  bab_pkg::t_blend_ctl i_ctl,
    input  bab_pkg::t_texel     i_old,
    input  bab_pkg::t_texel     i_new,
    output bab_pkg::t_texel     o_res
);
    import bab_pkg::*;

    t_texel r_mix;
    t_texel r_res;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_en) begin
            r_mix.red   <= blend_channel(i_old.red,   i_new.red,   i_new.alpha);
            r_mix.green <= blend_channel(i_old.green, i_new.green, i_new.alpha);
            r_mix.blue  <= blend_channel(i_old.blue,  i_new.blue,  i_new.alpha);
            r_mix.alpha <= sat_add8(i_old.alpha, i_new.alpha);
        end
        if (i_ctl.s2_en) begin
            r_res.red   <= div255(16'(r_mix.red)   * 16'(r_mix.alpha));
            r_res.green <= div255(16'(r_mix.green) * 16'(r_mix.alpha));
            r_res.blue  <= div255(16'(r_mix.blue)  * 16'(r_mix.alpha));
            r_res.alpha <= r_mix.alpha;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/brush_alpha_blend_blitter.sv =====
// Top level of the brush alpha-blend blitter: sequencer, config registers, texture store.
// A load transaction writes its texel straight into the 64K-entry texture memory when it
// is accepted. A blend transaction walks one read-modify-write of that memory: position
// and bounds, address and read, lerp, premultiply, write-back. No further item is taken
// until the sequencer has left write-back; a pixel outside the texture skips the read and
// the blend and goes from the address state straight to write-back. Write-back waits
// only while the output register is still full and not being read. Results sit in an
// output register, so a new item is taken while a result waits. The brush corner is
// latched on the first pixel of each pass. The store has no reset: blending a texel that
// was never loaded gives undefined color.
module brush_alpha_blend_blitter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bab_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bab_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [bab_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bab_pkg::CFG_W-1:0]           i_cfg_data
);
    import bab_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POS  = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [8:0]         r_tex_w, r_tex_h;
    logic [6:0]         r_brush_w, r_brush_h;
    logic [BCOL_W-1:0]  r_col, n_col, r_row, n_row;
    logic signed [15:0] r_cx, r_cy;
    t_texel             r_pix;
    logic [TEX_AW-1:0]  r_tx, r_ty;
    logic               r_inside, r_last;
    logic [STORE_AW-1:0] r_idx;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_acc, out_load, n_last;
    logic [8:0]         tw, th;
    logic [6:0]         bw, bh;
    logic signed [16:0] tx_s, ty_s;
    logic               pos_inside;
    logic [16:0]        rd_addr_full;
    logic [STORE_AW-1:0] rd_addr;
    logic               ram_we, ram_re;
    logic [STORE_AW-1:0] ram_waddr;
    t_texel             ram_wdata, ram_rdata, blend_res;
    t_blend_ctl         blend_ctl;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_WB) && (!r_out_valid || i_out_ready);

    assign tw = (r_tex_w > 9'(MAX_TEX_DIM)) ? 9'(MAX_TEX_DIM) : r_tex_w;
    assign th = (r_tex_h > 9'(MAX_TEX_DIM)) ? 9'(MAX_TEX_DIM) : r_tex_h;
    assign bw = (r_brush_w == 7'd0) ? 7'd1 :
                (r_brush_w > 7'(MAX_BRUSH_DIM)) ? 7'(MAX_BRUSH_DIM) : r_brush_w;
    assign bh = (r_brush_h == 7'd0) ? 7'd1 :
                (r_brush_h > 7'(MAX_BRUSH_DIM)) ? 7'(MAX_BRUSH_DIM) : r_brush_h;

    assign tx_s = 17'(r_cx) + 17'(r_col);
    assign ty_s = 17'(r_cy) + 17'(r_row);
    assign pos_inside = !tx_s[16] && !ty_s[16]
                     && (tx_s[15:0] < 16'(tw)) && (ty_s[15:0] < 16'(th));

    assign rd_addr_full = 17'(r_ty) * 17'(tw) + 17'(r_tx);
    assign rd_addr      = rd_addr_full[STORE_AW-1:0];

    // Pass position, advanced once per blend pixel
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_last = 1'b0;
        if (7'(r_col) + 7'd1 >= bw) begin
            n_col = '0;
            if (7'(r_row) + 7'd1 >= bh) begin
                n_row  = '0;
                n_last = 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.req_type == REQ_BLEND) begin
                    n_state = S_POS;
                end
            end
            S_POS:  n_state = S_ADDR;
            S_ADDR: n_state = r_inside ? S_READ : S_WB;
            S_READ: n_state = S_MUL;
            S_MUL:  n_state = S_WB;
            S_WB: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tex_w     <= 9'd256;
            r_tex_h     <= 9'd256;
            r_brush_w   <= 7'd16;
            r_brush_h   <= 7'd16;
            r_col       <= '0;
            r_row       <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TEX_W:   r_tex_w   <= i_cfg_data;
                    CFG_TEX_H:   r_tex_h   <= i_cfg_data;
                    CFG_BRUSH_W: r_brush_w <= i_cfg_data[6:0];
                    CFG_BRUSH_H: r_brush_h <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            // Latch the corner on the first pixel of a pass
            if (in_acc && i_in_data.req_type == REQ_BLEND && r_col == '0 && r_row == '0) begin
                r_cx <= i_in_data.corner_x;
                r_cy <= i_in_data.corner_y;
            end
            if (r_state == S_POS) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix.red   <= i_in_data.red;
            r_pix.green <= i_in_data.green;
            r_pix.blue  <= i_in_data.blue;
            r_pix.alpha <= i_in_data.alpha;
        end
        if (r_state == S_POS) begin
            r_tx     <= tx_s[TEX_AW-1:0];
            r_ty     <= ty_s[TEX_AW-1:0];
            r_inside <= pos_inside;
            r_last   <= n_last;
        end
        if (r_state == S_ADDR) begin
            r_idx <= rd_addr;
        end
        if (out_load) begin
            r_out.inside_res <= r_inside;
            r_out.texel_x    <= r_inside ? 8'(r_tx) : 8'd0;
            r_out.texel_y    <= r_inside ? 8'(r_ty) : 8'd0;
            r_out.out_red    <= r_inside ? blend_res.red   : 8'd0;
            r_out.out_green  <= r_inside ? blend_res.green : 8'd0;
            r_out.out_blue   <= r_inside ? blend_res.blue  : 8'd0;
            r_out.out_alpha  <= r_inside ? blend_res.alpha : 8'd0;
            r_out.pass_last  <= r_last;
        end
    end

    // Loads write at acceptance; inside blends write back when the result is loaded.
    // One item at a time, so a read never overlaps a pending write.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = blend_res;
        if (in_acc && i_in_data.req_type == REQ_LOAD) begin
            ram_we    = (17'(i_in_data.texel_index) < 17'(STORE_DEPTH));
            ram_waddr = i_in_data.texel_index[STORE_AW-1:0];
            ram_wdata.red   = i_in_data.red;
            ram_wdata.green = i_in_data.green;
            ram_wdata.blue  = i_in_data.blue;
            ram_wdata.alpha = i_in_data.alpha;
        end else if (out_load && r_inside) begin
            ram_we = 1'b1;
        end
    end

    assign ram_re = (r_state == S_ADDR) && r_inside;

    bab_ram #(
        .WIDTH ($bits(t_texel)),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign blend_ctl.s1_en = (r_state == S_READ);
    assign blend_ctl.s2_en = (r_state == S_MUL);

    bab_blend u_blend (
        .i_clk (i_clk),
        .i_ctl (blend_ctl),
        .i_old (ram_rdata),
        .i_new (r_pix),
        .o_res (blend_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_blend_enters_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.req_type == REQ_BLEND) |=> (r_state == S_POS))
        else $error("blend transaction did not start the sequencer");

    a_pass_end_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_last) |-> (r_col == '0 && r_row == '0))
        else $error("last-of-pass result without brush position wrap");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("result load did not raise output valid");

    a_inside_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_inside) |-> (9'(r_tx) < tw && 9'(r_ty) < th))
        else $error("inside result outside texture bounds");

    a_no_write_midblend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_MUL) |-> !ram_we)
        else $error("store written during read-modify-write");
`endif

endmodule

// ===== verif/blit_checker.sv =====
`timescale 1ns / 1ps
// Blit checker: mirrors the texture store and brush walk, predicts each blend result and compares.
module blit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  bab_pkg::t_in_item             i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  bab_pkg::t_out_item            i_out_data,
    input  logic                          i_cfg_we,
    input  logic [bab_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bab_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_inside,
    output int                            o_passes
);
    import bab_pkg::*;

    logic [CFG_W-1:0] tex_w_reg;
    logic [CFG_W-1:0] tex_h_reg;
    logic [6:0]       brush_w_reg;
    logic [6:0]       brush_h_reg;
    int               col_pos;
    int               row_pos;
    int               corner_x_l;
    int               corner_y_l;
    t_texel           texels [0:STORE_DEPTH-1];
    t_out_item        blend_results_due [$];

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("blit_checker: %t result %0d: %s got %0h want %0h",
                 $time, o_checked, what, got, want);
        o_mismatches++;
    endtask

    task automatic check_fields(input t_out_item got, input t_out_item want);
        if (got.inside_res !== want.inside_res)
            flag_mismatch("inside_res", 32'(got.inside_res), 32'(want.inside_res));
        if (got.texel_x !== want.texel_x)
            flag_mismatch("texel_x", 32'(got.texel_x), 32'(want.texel_x));
        if (got.texel_y !== want.texel_y)
            flag_mismatch("texel_y", 32'(got.texel_y), 32'(want.texel_y));
        if (got.out_red !== want.out_red)
            flag_mismatch("out_red", 32'(got.out_red), 32'(want.out_red));
        if (got.out_green !== want.out_green)
            flag_mismatch("out_green", 32'(got.out_green), 32'(want.out_green));
        if (got.out_blue !== want.out_blue)
            flag_mismatch("out_blue", 32'(got.out_blue), 32'(want.out_blue));
        if (got.out_alpha !== want.out_alpha)
            flag_mismatch("out_alpha", 32'(got.out_alpha), 32'(want.out_alpha));
        if (got.pass_last !== want.pass_last)
            flag_mismatch("pass_last", 32'(got.pass_last), 32'(want.pass_last));
    endtask

    // Integer division truncates toward zero, so the step never overshoots new.
    function automatic int mix_channel(input int oldc, input int newc, input int a);
        return oldc + (newc - oldc) * a / 255;
    endfunction

    task automatic blend_brush_pixel(input t_in_item px, output t_out_item res);
        int     tw;
        int     th;
        int     bw;
        int     bh;
        int     tx;
        int     ty;
        int     idx;
        int     a_sum;
        int     a_new;
        t_texel old_t;
        tw = (tex_w_reg > MAX_TEX_DIM) ? MAX_TEX_DIM : int'(tex_w_reg);
        th = (tex_h_reg > MAX_TEX_DIM) ? MAX_TEX_DIM : int'(tex_h_reg);
        bw = (brush_w_reg == 0) ? 1 :
             (brush_w_reg > MAX_BRUSH_DIM) ? MAX_BRUSH_DIM : int'(brush_w_reg);
        bh = (brush_h_reg == 0) ? 1 :
             (brush_h_reg > MAX_BRUSH_DIM) ? MAX_BRUSH_DIM : int'(brush_h_reg);
        if (col_pos == 0 && row_pos == 0) begin
            corner_x_l = $signed(px.corner_x);
            corner_y_l = $signed(px.corner_y);
        end
        tx  = corner_x_l + col_pos;
        ty  = corner_y_l + row_pos;
        res = '0;
        if (tx >= 0 && ty >= 0 && tx < tw && ty < th) begin
            idx   = ty * tw + tx;
            old_t = texels[idx];
            a_new = int'(px.alpha);
            a_sum = int'(old_t.alpha) + a_new;
            if (a_sum > 255)
                a_sum = 255;
            res.inside_res = 1'b1;
            res.texel_x    = 8'(tx);
            res.texel_y    = 8'(ty);
            res.out_red    = 8'(mix_channel(int'(old_t.red), int'(px.red), a_new)
                                * a_sum / 255);
            res.out_green  = 8'(mix_channel(int'(old_t.green), int'(px.green), a_new)
                                * a_sum / 255);
            res.out_blue   = 8'(mix_channel(int'(old_t.blue), int'(px.blue), a_new)
                                * a_sum / 255);
            res.out_alpha  = 8'(a_sum);
            texels[idx]    = {res.out_alpha, res.out_blue, res.out_green, res.out_red};
        end
        // A position at or past a shrunken size closes the row or the pass.
        if (col_pos + 1 >= bw) begin
            col_pos = 0;
            if (row_pos + 1 >= bh) begin
                row_pos       = 0;
                res.pass_last = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            tex_w_reg   = 9'd256;
            tex_h_reg   = 9'd256;
            brush_w_reg = 7'd16;
            brush_h_reg = 7'd16;
            col_pos     = 0;
            row_pos     = 0;
            corner_x_l  = 0;
            corner_y_l  = 0;
            blend_results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (blend_results_due.size() == 0) begin
                    flag_mismatch("result with nothing expected", 32'(i_out_data), 32'd0);
                end else begin
                    want = blend_results_due.pop_front();
                    check_fields(i_out_data, want);
                    o_checked++;
                    if (want.inside_res)
                        o_inside++;
                    if (want.pass_last)
                        o_passes++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TEX_W:   tex_w_reg = i_cfg_data;
                    CFG_TEX_H:   tex_h_reg = i_cfg_data;
                    CFG_BRUSH_W: brush_w_reg = i_cfg_data[6:0];
                    CFG_BRUSH_H: brush_h_reg = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.req_type == REQ_BLEND) begin
                    blend_brush_pixel(i_in_data, want);
                    blend_results_due.push_back(want);
                end else begin
                    texels[i_in_data.texel_index] = {i_in_data.alpha, i_in_data.blue,
                                                     i_in_data.green, i_in_data.red};
                end
            end
        end
        o_pending = blend_results_due.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the brush alpha-blend blitter: stimulus, idling and verdict.
module tb;
    import bab_pkg::*;

    localparam int IDLE_PCT     = 29;
    localparam int RANDOM_ITEMS = 950;
    localparam int SETTLE       = 10;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_data;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int pending;
    int checked;
    int inside_hits;
    int passes;

    // Stimulus-side view of the brush walk, used to aim passes and preload texels.
    bit steady;
    bit texel_loaded [0:STORE_DEPTH-1];
    int tw_now = MAX_TEX_DIM;
    int th_now = MAX_TEX_DIM;
    int bw_now = 16;
    int bh_now = 16;
    int col_at;
    int row_at;
    int anchor_x;
    int anchor_y;
    int items_sent;
    int phase;

    brush_alpha_blend_blitter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    blit_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_inside     (inside_hits),
        .o_passes     (passes)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic t_in_item random_item();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_texel random_color();
        t_texel c;
        c = t_texel'($urandom);
        case ($urandom_range(7))
            0: c.alpha = 8'h00;
            1: c.alpha = 8'hFF;
            default: ;
        endcase
        return c;
    endfunction

    function automatic int pick_corner(input int tex_dim, input int brush_dim);
        case ($urandom_range(9))
            0: return $signed(16'($urandom));
            1: return $urandom_range(1) ? -32768 : 32767;
            default: return int'($urandom_range(tex_dim + brush_dim)) - brush_dim;
        endcase
    endfunction

    function automatic int pick_tex_dim();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return MAX_TEX_DIM;
            3: return $urandom_range(511, 257);
            default: return $urandom_range(24, 1);
        endcase
    endfunction

    function automatic int pick_brush_dim();
        case ($urandom_range(9))
            0: return 0;
            1: return MAX_BRUSH_DIM;
            2: return $urandom_range(127, 65);
            default: return $urandom_range(5, 1);
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic load_texel(input int idx, input t_texel color);
        t_in_item it;
        it             = random_item();
        it.req_type    = REQ_LOAD;
        it.texel_index = 16'(idx);
        {it.alpha, it.blue, it.green, it.red} = color;
        texel_loaded[idx] = 1'b1;
        send_item(it);
    endtask

    // Send one brush pixel; load its texel first if the blend would read a blank one.
    task automatic paint_pixel(input t_texel color, input int cx, input int cy);
        t_in_item it;
        int       tx;
        int       ty;
        it          = random_item();
        it.req_type = REQ_BLEND;
        {it.alpha, it.blue, it.green, it.red} = color;
        if (col_at == 0 && row_at == 0) begin
            it.corner_x = 16'(cx);
            it.corner_y = 16'(cy);
            anchor_x    = $signed(it.corner_x);
            anchor_y    = $signed(it.corner_y);
        end
        tx = anchor_x + col_at;
        ty = anchor_y + row_at;
        if (tx >= 0 && ty >= 0 && tx < tw_now && ty < th_now)
            if (!texel_loaded[ty * tw_now + tx])
                load_texel(ty * tw_now + tx, random_color());
        send_item(it);
        if (col_at + 1 >= bw_now) begin
            col_at = 0;
            row_at = (row_at + 1 >= bh_now) ? 0 : row_at + 1;
        end else begin
            col_at++;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input int tex_w, input int tex_h,
                                input int br_w, input int br_h);
        wait_idle();
        put_reg(CFG_TEX_W, 9'(tex_w));
        put_reg(CFG_TEX_H, 9'(tex_h));
        // upper data bits are junk for the 7-bit brush registers
        put_reg(CFG_BRUSH_W, {2'($urandom), 7'(br_w)});
        put_reg(CFG_BRUSH_H, {2'($urandom), 7'(br_h)});
        cfg_we <= 1'b0;
        tw_now = (tex_w > MAX_TEX_DIM) ? MAX_TEX_DIM : tex_w;
        th_now = (tex_h > MAX_TEX_DIM) ? MAX_TEX_DIM : tex_h;
        bw_now = (br_w == 0) ? 1 : (br_w > MAX_BRUSH_DIM) ? MAX_BRUSH_DIM : br_w;
        bh_now = (br_h == 0) ? 1 : (br_h > MAX_BRUSH_DIM) ? MAX_BRUSH_DIM : br_h;
    endtask

    initial begin : stimulus
        int k;
        int directed_items;
        int n;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_TEX_W;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset sizes: 256x256 texture, 16x16 brush.
        load_texel(0, t_texel'(32'h0000_0000));
        load_texel(1, t_texel'(32'hFFFF_FFFF));
        load_texel(STORE_DEPTH - 1, t_texel'(32'hFFFF_FFFF));
        paint_pixel(t_texel'(32'hFFFF_FFFF), 0, 0);     // opaque white over blank black
        paint_pixel(t_texel'(32'hFF00_0000), 0, 0);     // opaque black over white, alpha saturates
        paint_pixel(t_texel'(32'h00FF_FFFF), 0, 0);     // zero alpha: the lerp keeps the old color
        // shrink the brush while the pass is three pixels in
        program_regs(4, 4, 2, 2);
        repeat (3) paint_pixel(random_color(), 0, 0);
        repeat (4) paint_pixel(random_color(), -1, -1);  // only the last pixel lands
        repeat (4) paint_pixel(random_color(), 3, 2);    // right column hangs off
        repeat (4) paint_pixel(random_color(), -32768, 32767);
        directed_items = items_sent;

        while (items_sent < directed_items + RANDOM_ITEMS) begin
            case (phase)
                0: program_regs(MAX_TEX_DIM, MAX_TEX_DIM, MAX_BRUSH_DIM, 1);
                1: program_regs(1, 1, 0, 1);
                2: program_regs(511, 0, 1, 100);
                3: program_regs(3, 300, 100, 2);
                default: program_regs(pick_tex_dim(), pick_tex_dim(),
                                      pick_brush_dim(), pick_brush_dim());
            endcase
            steady = (phase == 0);
            n = $urandom_range(110, 50);
            repeat (n) begin
                if ($urandom_range(99) < 8)
                    load_texel($urandom_range(STORE_DEPTH - 1), random_color());
                else
                    paint_pixel(random_color(), pick_corner(tw_now, bw_now),
                                pick_corner(th_now, bh_now));
            end
            phase++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        for (k = 0; k < 5000 && pending != 0; k++)
            @(posedge clk);
        repeat (2 * SETTLE) @(posedge clk);

        $display("tb: %0d items sent, %0d blend results checked, %0d inside, %0d passes closed",
                 items_sent, checked, inside_hits, passes);
        $display("tb: %0d register settings, texture sides 0..511, brush sides 0..127",
                 phase + 1);
        if (mismatches == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== brush_alpha_blend_blitter.f =====
rtl/bab_pkg.sv
rtl/bab_ram.sv
rtl/bab_blend.sv
rtl/brush_alpha_blend_blitter.sv
verif/blit_checker.sv
verif/tb.sv
